@@ rtl/core/lvs_pkg.sv @@
`timescale 1ns / 1ps
`default_nettype none

package lvs_pkg;

  // Command kinds on the result channel.
  localparam logic [1:0] KIND_HEAD  = 2'd0;
  localparam logic [1:0] KIND_TRUNC = 2'd1;
  localparam logic [1:0] KIND_FULL  = 2'd2;
  localparam logic [1:0] KIND_RAW   = 2'd3;

  localparam int unsigned EXP_BITS = 11;   // expectation bits kept before down-shift
  localparam int unsigned SHIFT_MAX = 6;   // 17-bit expectation minus EXP_BITS

  localparam logic [7:0]  DECAY_MAX     = 8'd254;
  localparam logic [7:0]  DECAY_MIN     = 8'd2;
  localparam logic [7:0]  TAIL_DECAY_TH = 8'd235;
  localparam logic [8:0]  CHUNK         = 9'd15;
  localparam logic [3:0]  SYM_MAX       = 4'd15;
  localparam logic [4:0]  ALPHA_FULL    = 5'd16;
  localparam logic [12:0] DIV_OFFSET    = 13'd256;
  localparam logic [15:0] SQ_ROUND      = 16'd128;

  // One classified item handed from the front to the back.
  typedef struct packed {
    logic [8:0] x;      // clamped value before rounding
    logic [8:0] xs;     // rounded value
    logic [8:0] ks;     // rounded bound
    logic [2:0] shift;  // down-shift amount
    logic [7:0] decay;  // head decay, capped
  } desc_t;

  typedef enum logic [1:0] {
    F_IDLE,
    F_DIV,
    F_PUSH
  } front_state_t;

  typedef enum logic [2:0] {
    B_IDLE,
    B_HEAD,
    B_RAW,
    B_SQ,
    B_CHUNK,
    B_TRAW
  } back_state_t;

endpackage

`default_nettype wire

@@ rtl/core/lvs_in_if.sv @@
`timescale 1ns / 1ps
`default_nettype none

interface lvs_in_if;
  logic        valid;
  logic        ready;
  logic [8:0]  value;
  logic [16:0] expect_q8;
  logic [8:0]  bound;

  modport source(output valid, output value, output expect_q8, output bound, input ready);
  modport sink(input valid, input value, input expect_q8, input bound, output ready);
endinterface

`default_nettype wire

@@ rtl/core/lvs_out_if.sv @@
`timescale 1ns / 1ps
`default_nettype none

interface lvs_out_if;
  logic        valid;
  logic        ready;
  logic [1:0]  kind;
  logic [3:0]  symbol;
  logic [6:0]  table_row;
  logic [4:0]  alphabet;
  logic [15:0] raw_value;
  logic [4:0]  raw_count;
  logic        last;

  modport source(output valid, output kind, output symbol, output table_row,
                 output alphabet, output raw_value, output raw_count, output last,
                 input ready);
  modport sink(input valid, input kind, input symbol, input table_row,
               input alphabet, input raw_value, input raw_count, input last,
               output ready);
endinterface

`default_nettype wire

@@ rtl/core/laplace_value_symbolizer_core.sv @@
`timescale 1ns / 1ps
`default_nettype none

// Laplace value symbolizer. Each input item (value, expected magnitude in
// unsigned Q8, bound) becomes an ordered run of range-coder commands on the
// output channel: a head symbol, raw low bits when the expectation forces a
// down-shift, and for large values a tail of 15-symbol chunks with its own
// raw bits; the final command of an item carries last. An item that yields
// no command produces nothing on the output. The front stage clamps and
// rounds the inputs and computes the decay with a restoring divider that
// makes one quotient bit per cycle; it accepts an item, runs eight divide
// steps and then hands the item off, and takes the next item only once the
// hand-off, which waits while the queue is full, is done. A two-entry queue
// decouples it from the back stage, which emits one command per cycle while
// the output is taken. Besides emitting commands, the back stage picks up
// each item, passes through the head state without output when there is
// no head symbol, and for a tail runs up to four decay squaring steps and
// then sets up the chunks. The output is registered; while a finished
// command waits to be taken, the back stage can still pick up an item and
// square the decay, but holds its next command until the output is free.

module laplace_value_symbolizer_core #(
  parameter int unsigned MAX_BOUND = 511
) (
  input  wire logic   clk,
  input  wire logic   rst_n,
  lvs_in_if.sink      in_ch,
  lvs_out_if.source   out_ch
);

  logic           push_valid;
  lvs_pkg::desc_t push_data;
  logic           q_full;
  logic           q_pop;
  logic           q_valid;
  lvs_pkg::desc_t q_data;

  // Front: clamp, round and divide; one classified item per hand-off.
  lvs_front #(
    .MAX_BOUND(MAX_BOUND)
  ) u_front (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_ch     (in_ch),
    .push_valid(push_valid),
    .push_data (push_data),
    .q_full    (q_full)
  );

  lvs_queue u_queue (
    .clk      (clk),
    .rst_n    (rst_n),
    .push     (push_valid),
    .push_data(push_data),
    .full     (q_full),
    .pop      (q_pop),
    .pop_valid(q_valid),
    .pop_data (q_data)
  );

  // Back: command sequencer with the registered output stage.
  lvs_back u_back (
    .clk    (clk),
    .rst_n  (rst_n),
    .q_valid(q_valid),
    .q_data (q_data),
    .q_pop  (q_pop),
    .out_ch (out_ch)
  );

endmodule

`default_nettype wire

@@ rtl/core/lvs_front.sv @@
`timescale 1ns / 1ps
`default_nettype none

module lvs_front #(
  parameter int unsigned MAX_BOUND = 511
) (
  input  wire logic          clk,
  input  wire logic          rst_n,
  lvs_in_if.sink             in_ch,
  output logic               push_valid,
  output lvs_pkg::desc_t     push_data,
  input  wire logic          q_full
);

  lvs_pkg::front_state_t state_r, state_nxt;

  logic [8:0]  x_r, xs_r, ks_r;
  logic [2:0]  sh_r;
  logic [19:0] rem_r, rem_nxt;
  logic [12:0] div_r;
  logic [7:0]  q_r, q_nxt;
  logic [2:0]  cnt_r;

  logic        acc;
  logic [8:0]  kc, xc;
  logic [2:0]  sh;
  logic [5:0]  half;
  logic [17:0] e_sum;
  logic [11:0] e_rnd;
  logic [8:0]  k_rnd, x_rnd;
  logic [20:0] diff;
  logic        ge;

  assign acc = in_ch.valid && in_ch.ready;

  // Clamp, find the down-shift and round everything by it.
  always_comb begin
    kc = (in_ch.bound > 9'(MAX_BOUND)) ? 9'(MAX_BOUND) : in_ch.bound;
    xc = (in_ch.value > kc) ? kc : in_ch.value;
    sh = 3'd0;
    for (int i = 0; i < lvs_pkg::SHIFT_MAX; i++) begin
      if (in_ch.expect_q8[lvs_pkg::EXP_BITS + i]) begin
        sh = 3'(i + 1);
      end
    end
    half  = (sh == 3'd0) ? 6'd0 : (6'd1 << (sh - 3'd1));
    e_sum = {1'b0, in_ch.expect_q8} + 18'(half);
    e_rnd = 12'(e_sum >> sh);
    k_rnd = 9'(({1'b0, kc} + 10'(half)) >> sh);
    x_rnd = 9'(({1'b0, xc} + 10'(half)) >> sh);
  end

  // One restoring quotient bit per cycle.
  always_comb begin
    diff    = {1'b0, rem_r} - (21'(div_r) << cnt_r);
    ge      = !diff[20];
    rem_nxt = ge ? diff[19:0] : rem_r;
    q_nxt   = {q_r[6:0], ge};
  end

  always_comb begin
    state_nxt = state_r;
    case (state_r)
      lvs_pkg::F_IDLE: if (acc) state_nxt = lvs_pkg::F_DIV;
      lvs_pkg::F_DIV:  if (cnt_r == 3'd0) state_nxt = lvs_pkg::F_PUSH;
      lvs_pkg::F_PUSH: if (!q_full) state_nxt = lvs_pkg::F_IDLE;
      default:         state_nxt = lvs_pkg::F_IDLE;
    endcase
  end

  always_comb begin
    in_ch.ready      = (state_r == lvs_pkg::F_IDLE);
    push_valid       = (state_r == lvs_pkg::F_PUSH) && !q_full;
    push_data.x      = x_r;
    push_data.xs     = xs_r;
    push_data.ks     = ks_r;
    push_data.shift  = sh_r;
    push_data.decay  = (q_r > lvs_pkg::DECAY_MAX) ? lvs_pkg::DECAY_MAX : q_r;
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= lvs_pkg::F_IDLE;
    end else begin
      state_r <= state_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (acc) begin
      x_r   <= xc;
      xs_r  <= x_rnd;
      ks_r  <= k_rnd;
      sh_r  <= sh;
      rem_r <= {e_rnd, 8'd0};
      div_r <= 13'(e_rnd) + lvs_pkg::DIV_OFFSET;
      q_r   <= 8'd0;
      cnt_r <= 3'd7;
    end else if (state_r == lvs_pkg::F_DIV) begin
      rem_r <= rem_nxt;
      q_r   <= q_nxt;
      cnt_r <= cnt_r - 3'd1;
    end
  end

endmodule

`default_nettype wire

@@ rtl/core/lvs_queue.sv @@
`timescale 1ns / 1ps
`default_nettype none

module lvs_queue (
  input  wire logic          clk,
  input  wire logic          rst_n,
  input  wire logic          push,
  input  lvs_pkg::desc_t     push_data,
  output logic               full,
  input  wire logic          pop,
  output logic               pop_valid,
  output lvs_pkg::desc_t     pop_data
);

  lvs_pkg::desc_t mem_r [2];
  logic           wr_ptr_r, rd_ptr_r;
  logic [1:0]     cnt_r;

  assign full      = (cnt_r == 2'd2);
  assign pop_valid = (cnt_r != 2'd0);
  assign pop_data  = mem_r[rd_ptr_r];

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      wr_ptr_r <= 1'b0;
      rd_ptr_r <= 1'b0;
      cnt_r    <= 2'd0;
    end else begin
      if (push) wr_ptr_r <= !wr_ptr_r;
      if (pop)  rd_ptr_r <= !rd_ptr_r;
      cnt_r <= cnt_r + 2'(push) - 2'(pop);
    end
  end

  always_ff @(posedge clk) begin
    if (push) mem_r[wr_ptr_r] <= push_data;
  end

endmodule

`default_nettype wire

@@ rtl/core/lvs_back.sv @@
`timescale 1ns / 1ps
`default_nettype none

module lvs_back (
  input  wire logic          clk,
  input  wire logic          rst_n,
  input  wire logic          q_valid,
  input  lvs_pkg::desc_t     q_data,
  output logic               q_pop,
  lvs_out_if.source          out_ch
);

  lvs_pkg::back_state_t state_r, state_nxt;
  lvs_pkg::desc_t       d_r;

  logic [8:0] tx_r, tmax_r, cx_r, cm_r;
  logic [7:0] td_r;
  logic [2:0] tsh_r;

  logic        out_valid_r;
  logic [1:0]  kind_r;
  logic [3:0]  symbol_r;
  logic [6:0]  row_r;
  logic [4:0]  alpha_r;
  logic [15:0] rv_r;
  logic [4:0]  rc_r;
  logic        last_r;

  logic        out_free, emit, fire;
  logic [1:0]  c_kind;
  logic [3:0]  c_sym;
  logic [6:0]  c_row;
  logic [4:0]  c_alpha;
  logic [15:0] c_rv;
  logic [4:0]  c_rc;
  logic        c_last;

  logic        has_head, has_raw, has_tail;
  logic [5:0]  half;
  logic [6:0]  hmask;
  logic [9:0]  xsum;
  logic        sq_go;
  logic [15:0] sq;
  logic [7:0]  td_clamp;
  logic [8:0]  cx_n, cm_n;
  logic        cont;
  logic [8:0]  tmask;

  assign out_free = !out_valid_r || out_ch.ready;
  assign fire     = emit && out_free;
  assign q_pop    = (state_r == lvs_pkg::B_IDLE) && q_valid;

  always_comb begin
    has_head = (d_r.ks != 9'd0);
    has_raw  = (d_r.shift != 3'd0) && ((d_r.xs != 9'd0) || (d_r.shift > 3'd1));
    has_tail = (d_r.xs >= lvs_pkg::CHUNK) && (d_r.ks > lvs_pkg::CHUNK);
    half     = (d_r.shift == 3'd0) ? 6'd0 : (6'd1 << (d_r.shift - 3'd1));
    hmask    = (7'd1 << d_r.shift) - 7'd1;
    xsum     = {1'b0, d_r.x} + 10'(half);
    sq_go    = ((tmax_r >> tsh_r) >= lvs_pkg::CHUNK) && (td_r > lvs_pkg::TAIL_DECAY_TH);
    sq       = 16'(td_r) * 16'(td_r) + lvs_pkg::SQ_ROUND;
    td_clamp = (td_r > lvs_pkg::DECAY_MAX) ? lvs_pkg::DECAY_MAX :
               (td_r < lvs_pkg::DECAY_MIN) ? lvs_pkg::DECAY_MIN : td_r;
    cx_n     = (cx_r >= lvs_pkg::CHUNK) ? cx_r - lvs_pkg::CHUNK : 9'd0;
    cm_n     = (cm_r >= lvs_pkg::CHUNK) ? cm_r - lvs_pkg::CHUNK : 9'd0;
    cont     = (cx_r >= lvs_pkg::CHUNK) && (cm_n != 9'd0);
    tmask    = (9'd1 << tsh_r) - 9'd1;
  end

  // Command built in the current state.
  always_comb begin
    emit    = 1'b0;
    c_kind  = lvs_pkg::KIND_RAW;
    c_sym   = 4'd0;
    c_row   = 7'd0;
    c_alpha = 5'd0;
    c_rv    = 16'd0;
    c_rc    = 5'd0;
    c_last  = 1'b0;
    case (state_r)
      lvs_pkg::B_HEAD: begin
        emit    = has_head;
        c_kind  = lvs_pkg::KIND_HEAD;
        c_sym   = (d_r.xs >= lvs_pkg::CHUNK) ? lvs_pkg::SYM_MAX : d_r.xs[3:0];
        c_row   = 7'(({1'b0, d_r.decay} + 9'd1) >> 1);
        c_alpha = (d_r.ks >= lvs_pkg::CHUNK) ? lvs_pkg::ALPHA_FULL : 5'(d_r.ks + 9'd1);
        c_last  = !has_raw && !has_tail;
      end
      lvs_pkg::B_RAW: begin
        emit   = 1'b1;
        c_rv   = (d_r.xs == 9'd0) ? 16'(d_r.x) : 16'(xsum & {3'd0, hmask});
        c_rc   = (d_r.xs == 9'd0) ? 5'(d_r.shift - 3'd1) : 5'(d_r.shift);
        c_last = !has_tail;
      end
      lvs_pkg::B_CHUNK: begin
        emit   = 1'b1;
        c_sym  = (cx_r >= lvs_pkg::CHUNK) ? lvs_pkg::SYM_MAX : cx_r[3:0];
        c_row  = 7'(({1'b0, td_r} + 9'd1) >> 1);
        if ((cm_r != 9'd0) && (cm_r < lvs_pkg::CHUNK)) begin
          c_kind  = lvs_pkg::KIND_TRUNC;
          c_alpha = 5'(cm_r + 9'd1);
        end else begin
          c_kind  = lvs_pkg::KIND_FULL;
          c_alpha = lvs_pkg::ALPHA_FULL;
        end
        c_last = !cont && (tsh_r == 3'd0);
      end
      lvs_pkg::B_TRAW: begin
        emit   = 1'b1;
        c_rv   = 16'(tx_r & tmask);
        c_rc   = 5'(tsh_r);
        c_last = 1'b1;
      end
      default: emit = 1'b0;
    endcase
  end

  always_comb begin
    state_nxt = state_r;
    case (state_r)
      lvs_pkg::B_IDLE: if (q_valid) state_nxt = lvs_pkg::B_HEAD;
      lvs_pkg::B_HEAD: begin
        if (!has_head || fire) begin
          state_nxt = has_raw ? lvs_pkg::B_RAW :
                      has_tail ? lvs_pkg::B_SQ : lvs_pkg::B_IDLE;
        end
      end
      lvs_pkg::B_RAW: if (fire) state_nxt = has_tail ? lvs_pkg::B_SQ : lvs_pkg::B_IDLE;
      lvs_pkg::B_SQ:  if (!sq_go) state_nxt = lvs_pkg::B_CHUNK;
      lvs_pkg::B_CHUNK: begin
        if (fire && !cont) begin
          state_nxt = (tsh_r != 3'd0) ? lvs_pkg::B_TRAW : lvs_pkg::B_IDLE;
        end
      end
      lvs_pkg::B_TRAW: if (fire) state_nxt = lvs_pkg::B_IDLE;
      default:         state_nxt = lvs_pkg::B_IDLE;
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= lvs_pkg::B_IDLE;
      out_valid_r <= 1'b0;
    end else begin
      state_r <= state_nxt;
      if (out_free) out_valid_r <= emit;
    end
  end

  always_ff @(posedge clk) begin
    if (fire) begin
      kind_r   <= c_kind;
      symbol_r <= c_sym;
      row_r    <= c_row;
      alpha_r  <= c_alpha;
      rv_r     <= c_rv;
      rc_r     <= c_rc;
      last_r   <= c_last;
    end
    if (q_pop) d_r <= q_data;
    case (state_r)
      lvs_pkg::B_HEAD: begin
        tx_r   <= d_r.xs - lvs_pkg::CHUNK;
        tmax_r <= d_r.ks - lvs_pkg::CHUNK;
        td_r   <= d_r.decay;
        tsh_r  <= 3'd0;
      end
      lvs_pkg::B_SQ: begin
        if (sq_go) begin
          td_r  <= sq[15:8];
          tsh_r <= tsh_r + 3'd1;
        end else begin
          td_r <= td_clamp;
          cx_r <= tx_r >> tsh_r;
          cm_r <= tmax_r >> tsh_r;
        end
      end
      lvs_pkg::B_CHUNK: begin
        if (fire) begin
          cx_r <= cx_n;
          cm_r <= cm_n;
        end
      end
      default: begin
      end
    endcase
  end

  always_comb begin
    out_ch.valid     = out_valid_r;
    out_ch.kind      = kind_r;
    out_ch.symbol    = symbol_r;
    out_ch.table_row = row_r;
    out_ch.alphabet  = alpha_r;
    out_ch.raw_value = rv_r;
    out_ch.raw_count = rc_r;
    out_ch.last      = last_r;
  end

endmodule

`default_nettype wire
